FILE: hw/rtl/timer_and_interrupt_dispatch_macros.svh
// Assertion helpers used by the checker file.
`ifndef TIMER_AND_INTERRUPT_DISPATCH_MACROS_SVH
`define TIMER_AND_INTERRUPT_DISPATCH_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define TID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also runs across reset.
`define TID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/tid_pkg.sv
package tid_pkg;

  // Step commands
  typedef enum logic [1:0] {
    CMD_STEP    = 2'd0,
    CMD_IME_SET = 2'd1,
    CMD_IME_CLR = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_IRQ_EN     = 2'd0,
    CFG_TMR_EN     = 2'd1,
    CFG_TMR_RELOAD = 2'd2,
    CFG_RATE_SHIFT = 2'd3
  } cfg_idx_e;

  localparam logic [6:0] VecBase        = 7'h40;
  localparam logic [4:0] DispatchCycles = 5'd20;
  localparam logic [4:0] TimerIrqMask   = 5'b00100;
  localparam logic [4:0] FlagsReset     = 5'b00001;
  localparam logic [3:0] ShiftMin       = 4'd4;
  localparam logic [3:0] ShiftMax       = 4'd10;
  localparam logic [3:0] ShiftReset     = 4'd10;

  // Next timer state from the timer unit
  typedef struct packed {
    logic [15:0] div;
    logic [10:0] acc;
    logic [7:0]  tima;
    logic        ovf;
  } tmr_next_t;

  // Interrupt selection
  typedef struct packed {
    logic       taken;
    logic [2:0] idx;
  } disp_t;

  // Registered input item
  typedef struct packed {
    cmd_e        command;
    logic [5:0]  ticks;
    logic [4:0]  irq_raise;
    logic [15:0] return_pc;
    logic [15:0] stack_ptr;
  } in_item_t;

  // Registered result item
  typedef struct packed {
    logic        dispatch;
    logic [6:0]  vector;
    logic [15:0] new_stack_ptr;
    logic [7:0]  push_high_byte;
    logic [7:0]  push_low_byte;
    logic [4:0]  extra_cycles;
    logic [7:0]  div_value;
    logic [7:0]  tima_value;
    logic [4:0]  pending_flags;
  } out_item_t;

endpackage

FILE: hw/rtl/tid_if.sv
// Step item channel
interface tid_in_if;
  import tid_pkg::*;
  logic        valid;
  logic        ready;
  cmd_e        command;
  logic [5:0]  ticks;
  logic [4:0]  irq_raise;
  logic [15:0] return_pc;
  logic [15:0] stack_ptr;

  modport source (output valid, command, ticks, irq_raise, return_pc, stack_ptr,
                  input ready);
  modport sink   (input valid, command, ticks, irq_raise, return_pc, stack_ptr,
                  output ready);
endinterface

// Result item channel
interface tid_out_if;
  logic        valid;
  logic        ready;
  logic        dispatch;
  logic [6:0]  vector;
  logic [15:0] new_stack_ptr;
  logic [7:0]  push_high_byte;
  logic [7:0]  push_low_byte;
  logic [4:0]  extra_cycles;
  logic [7:0]  div_value;
  logic [7:0]  tima_value;
  logic [4:0]  pending_flags;

  modport source (output valid, dispatch, vector, new_stack_ptr, push_high_byte,
                  push_low_byte, extra_cycles, div_value, tima_value, pending_flags,
                  input ready);
  modport sink   (input valid, dispatch, vector, new_stack_ptr, push_high_byte,
                  push_low_byte, extra_cycles, div_value, tima_value, pending_flags,
                  output ready);
endinterface

// Register write channel
interface tid_cfg_if;
  import tid_pkg::*;
  logic       valid;
  logic       ready;
  cfg_idx_e   index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tid_timer.sv
module tid_timer (
  input  logic [15:0]       div_i,
  input  logic [10:0]       acc_i,
  input  logic [7:0]        tima_i,
  input  logic [5:0]        ticks_i,
  input  logic              en_i,
  input  logic [3:0]        shift_i,
  input  logic [7:0]        reload_i,
  output tid_pkg::tmr_next_t nxt_o
);
  import tid_pkg::*;

  logic [3:0]  sh;
  logic [11:0] acc_sum;
  logic [11:0] inc_w;
  logic [11:0] rem_mask;
  logic [11:0] rem;
  logic [8:0]  tima_sum;

  // clamp the rate shift so the accumulator stays within 11 bits
  always_comb begin
    if (shift_i < ShiftMin) begin
      sh = ShiftMin;
    end else if (shift_i > ShiftMax) begin
      sh = ShiftMax;
    end else begin
      sh = shift_i;
    end
  end

  // whole TIMA increments and the leftover ticks
  assign acc_sum  = {1'b0, acc_i} + {6'd0, ticks_i};
  assign inc_w    = acc_sum >> sh;
  assign rem_mask = (12'd1 << sh) - 12'd1;
  assign rem      = acc_sum & rem_mask;
  assign tima_sum = {1'b0, tima_i} + {1'b0, inc_w[7:0]};

  always_comb begin
    nxt_o.div  = div_i + {10'd0, ticks_i};
    nxt_o.acc  = acc_i;
    nxt_o.tima = tima_i;
    nxt_o.ovf  = 1'b0;
    if (en_i) begin
      nxt_o.acc = rem[10:0];
      nxt_o.ovf = tima_sum[8];
      // overflow reloads; increments past the wrap are dropped
      nxt_o.tima = tima_sum[8] ? reload_i : tima_sum[7:0];
    end
  end

endmodule

FILE: hw/rtl/tid_dispatch.sv
module tid_dispatch (
  input  logic [4:0]     flags_i,
  input  logic [4:0]     mask_i,
  input  logic           ime_i,
  input  logic           step_i,
  output tid_pkg::disp_t disp_o
);
  import tid_pkg::*;

  logic [4:0] pend;

  assign pend = flags_i & mask_i;

  // lowest pending enabled source wins
  always_comb begin
    disp_o.idx = 3'd0;
    for (int i = 4; i >= 0; i--) begin
      if (pend[i]) begin
        disp_o.idx = 3'(i);
      end
    end
    disp_o.taken = step_i && ime_i && (pend != 5'd0);
  end

endmodule

FILE: hw/rtl/timer_and_interrupt_dispatch.sv
// An accepted item waits in the input register, then in the output register until taken.
// Throughput: one item per cycle unless the output stalls; state updates in the result stage.
// A stalled result holds in the output register while the input register takes one more.
// Reset: DIV, accumulator and TIMA clear, pending flags = 1, master enable = 1,
// irq enable = 0, timer off, reload = 0, rate shift = 10; pipeline empties.
module timer_and_interrupt_dispatch (
  input  logic       clk_i,
  input  logic       rst_ni,
  tid_in_if.sink     in_i,
  tid_out_if.source  out_o,
  tid_cfg_if.sink    cfg_i
);
  import tid_pkg::*;

  // configuration
  logic [4:0]  irq_en_q;
  logic        tmr_en_q;
  logic [7:0]  reload_q;
  logic [3:0]  shift_q;

  // architectural state
  logic [15:0] div_q, div_d;
  logic [10:0] acc_q, acc_d;
  logic [7:0]  tima_q, tima_d;
  logic [4:0]  flags_q, flags_d;
  logic        ime_q, ime_d;

  // pipeline
  logic        s1_valid_q;
  in_item_t    s1_q;
  logic        out_valid_q;
  out_item_t   out_q, out_d;
  logic        adv;

  tmr_next_t   tmr;
  disp_t       disp;
  logic        is_step;
  logic [4:0]  flags_t;

  // handshakes
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q <= 5'd0;
      tmr_en_q <= 1'b0;
      reload_q <= 8'd0;
      shift_q  <= ShiftReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_IRQ_EN:     irq_en_q <= cfg_i.data[4:0];
        CFG_TMR_EN:     tmr_en_q <= cfg_i.data[0];
        CFG_TMR_RELOAD: reload_q <= cfg_i.data;
        CFG_RATE_SHIFT: shift_q  <= cfg_i.data[3:0];
        default:        irq_en_q <= irq_en_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.command   <= in_i.command;
      s1_q.ticks     <= in_i.ticks;
      s1_q.irq_raise <= in_i.irq_raise;
      s1_q.return_pc <= in_i.return_pc;
      s1_q.stack_ptr <= in_i.stack_ptr;
    end
  end

  tid_timer u_timer (
    .div_i    (div_q),
    .acc_i    (acc_q),
    .tima_i   (tima_q),
    .ticks_i  (s1_q.ticks),
    .en_i     (tmr_en_q),
    .shift_i  (shift_q),
    .reload_i (reload_q),
    .nxt_o    (tmr)
  );

  assign is_step = (s1_q.command == CMD_STEP);
  assign flags_t = flags_q | s1_q.irq_raise | (tmr.ovf ? TimerIrqMask : 5'd0);

  tid_dispatch u_dispatch (
    .flags_i (flags_t),
    .mask_i  (irq_en_q),
    .ime_i   (ime_q),
    .step_i  (is_step),
    .disp_o  (disp)
  );

  // next state per command
  always_comb begin
    div_d   = div_q;
    acc_d   = acc_q;
    tima_d  = tima_q;
    flags_d = flags_q;
    ime_d   = ime_q;
    unique case (s1_q.command)
      CMD_STEP: begin
        div_d   = tmr.div;
        acc_d   = tmr.acc;
        tima_d  = tmr.tima;
        flags_d = disp.taken ? (flags_t & ~(5'd1 << disp.idx)) : flags_t;
        ime_d   = disp.taken ? 1'b0 : ime_q;
      end
      CMD_IME_SET: ime_d = 1'b1;
      CMD_IME_CLR: ime_d = 1'b0;
      CMD_NOP:     ime_d = ime_q;
      default:     ime_d = ime_q;
    endcase
  end

  // result item
  always_comb begin
    out_d.dispatch       = disp.taken;
    out_d.vector         = disp.taken ? (VecBase + {1'b0, disp.idx, 3'b000}) : 7'd0;
    out_d.new_stack_ptr  = disp.taken ? (s1_q.stack_ptr - 16'd2) : s1_q.stack_ptr;
    out_d.push_high_byte = disp.taken ? s1_q.return_pc[15:8] : 8'd0;
    out_d.push_low_byte  = disp.taken ? s1_q.return_pc[7:0] : 8'd0;
    out_d.extra_cycles   = disp.taken ? DispatchCycles : 5'd0;
    out_d.div_value      = div_d[15:8];
    out_d.tima_value     = tima_d;
    out_d.pending_flags  = flags_d;
  end

  // state registers, updated as an item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= 16'd0;
      acc_q   <= 11'd0;
      tima_q  <= 8'd0;
      flags_q <= FlagsReset;
      ime_q   <= 1'b1;
    end else if (adv) begin
      div_q   <= div_d;
      acc_q   <= acc_d;
      tima_q  <= tima_d;
      flags_q <= flags_d;
      ime_q   <= ime_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= adv || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.dispatch       = out_q.dispatch;
  assign out_o.vector         = out_q.vector;
  assign out_o.new_stack_ptr  = out_q.new_stack_ptr;
  assign out_o.push_high_byte = out_q.push_high_byte;
  assign out_o.push_low_byte  = out_q.push_low_byte;
  assign out_o.extra_cycles   = out_q.extra_cycles;
  assign out_o.div_value      = out_q.div_value;
  assign out_o.tima_value     = out_q.tima_value;
  assign out_o.pending_flags  = out_q.pending_flags;

endmodule

FILE: hw/rtl/tid_checker.sv
`include "timer_and_interrupt_dispatch_macros.svh"

module tid_checker (
  input logic       clk_i,
  input logic       rst_ni,
  tid_in_if.sink    in_i,
  tid_out_if.source out_o,
  tid_cfg_if.sink   cfg_i
);

  // a stalled result stays put
  `TID_ASSERT(a_out_hold, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.new_stack_ptr) && $stable(out_o.tima_value) && $stable(out_o.pending_flags), "stalled result changed")

  // pipeline comes out of reset empty
  `TID_ASSERT_ALWAYS(a_rst_empty, $rose(rst_ni) |-> !out_o.valid && in_i.ready && cfg_i.ready, "not empty after reset")

  // input only backs up when the result side is stalled
  `TID_ASSERT(a_backpressure, !in_i.ready |-> out_o.valid && !out_o.ready, "input stalled without output stall")

  // dispatch fields agree with each other
  `TID_ASSERT(a_disp_fields, out_o.valid && out_o.dispatch |-> out_o.extra_cycles == 5'd20 && (out_o.vector == 7'd64 || out_o.vector == 7'd72 || out_o.vector == 7'd80 || out_o.vector == 7'd88 || out_o.vector == 7'd96), "bad dispatch fields")

endmodule

bind timer_and_interrupt_dispatch tid_checker u_tid_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o),
  .cfg_i  (cfg_i)
);
